### rtl/wkot_pkg.sv
// ----------------------------------------------------------------------------
// wkot_pkg
// shared types, codes and defaults of the wildcard key object table
// ----------------------------------------------------------------------------
`default_nettype none

package wkot_pkg;

  localparam int unsigned DEF_ENTRIES = 64;
  localparam int unsigned KEY_W       = 16;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_DEL   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] first;
    logic [KEY_W-1:0] second;
    logic [KEY_W-1:0] third;
  } key_t;

  // one table row: valid flag plus the packed triple
  typedef struct packed {
    logic valid;
    key_t keys;
  } row_t;

endpackage

`default_nettype wire

### rtl/wkot_if.sv
// ----------------------------------------------------------------------------
// wkot_req_if / wkot_rsp_if
// valid/ready channels for commands and results of the object table
// ----------------------------------------------------------------------------
`default_nettype none

interface wkot_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] first_key;
  logic [15:0] second_key;
  logic [15:0] third_key;
  logic        first_any;
  logic        second_any;
  logic        third_any;

  modport source (
    output valid, cmd, first_key, second_key, third_key,
           first_any, second_any, third_any,
    input  ready
  );
  modport sink (
    input  valid, cmd, first_key, second_key, third_key,
           first_any, second_any, third_any,
    output ready
  );
endinterface

interface wkot_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       present;

  modport source (output valid, status, present, input ready);
  modport sink (input valid, status, present, output ready);
endinterface

`default_nettype wire

### rtl/wkot_mem.sv
// ----------------------------------------------------------------------------
// wkot_mem
// table storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module wkot_mem
  import wkot_pkg::*;
#(
  parameter int unsigned ENTRIES = DEF_ENTRIES,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire row_t          wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output row_t               rdata_o
);

  row_t mem [ENTRIES];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/wkot_match.sv
// ----------------------------------------------------------------------------
// wkot_match
// shared row comparator: exact or per-key wildcard match of one stored row
// ----------------------------------------------------------------------------
`default_nettype none

module wkot_match
  import wkot_pkg::*;
(
  input  wire row_t       row_i,
  input  wire key_t       key_i,
  input  wire logic [2:0] any_i,     // first, second, third
  input  wire logic       wild_en_i,
  output logic            hit_o
);

  logic m_first;
  logic m_second;
  logic m_third;

  always_comb begin
    m_first  = (wild_en_i & any_i[2]) | (row_i.keys.first  == key_i.first);
    m_second = (wild_en_i & any_i[1]) | (row_i.keys.second == key_i.second);
    m_third  = (wild_en_i & any_i[0]) | (row_i.keys.third  == key_i.third);
    hit_o    = row_i.valid & m_first & m_second & m_third;
  end

endmodule

`default_nettype wire

### rtl/wkot_seq.sv
// ----------------------------------------------------------------------------
// wkot_seq
// command sequencer: sweeps the table one row per cycle through the shared
// comparator, applies the command and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module wkot_seq
  import wkot_pkg::*;
#(
  parameter int unsigned ENTRIES = DEF_ENTRIES,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  wkot_req_if.sink        req_i,
  wkot_rsp_if.source      rsp_o,
  // table port
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output row_t            mem_wdata_o,
  output logic            mem_re_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  wire row_t       mem_rdata_i,
  // comparator
  output key_t            cmp_key_o,
  output logic [2:0]      cmp_any_o,
  output logic            cmp_wild_o,
  input  wire logic       cmp_hit_i
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_CLEAR,
    S_FINISH
  } state_e;

  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          issue_q, issue_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  cmd_e          cmd_q, cmd_d;
  key_t          key_q, key_d;
  logic [2:0]    any_q, any_d;
  logic          dup_q, dup_d;
  logic          free_q, free_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic          rsp_vld_q, rsp_vld_d;
  status_e       rsp_status_q, rsp_status_d;
  logic          rsp_present_q, rsp_present_d;

  logic          dup_now;
  logic          free_now;
  logic [AW-1:0] free_idx_now;

  assign cmp_key_o  = key_q;
  assign cmp_any_o  = any_q;
  assign cmp_wild_o = (cmd_q == CMD_DEL);

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.status  = rsp_status_q;
  assign rsp_o.present = rsp_present_q;

  // running add/query state including the row on the read port now
  assign dup_now      = dup_q | (rd_vld_q & cmp_hit_i);
  assign free_now     = free_q | (rd_vld_q & ~mem_rdata_i.valid);
  assign free_idx_now = free_q ? free_idx_q : rd_idx_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    issue_d       = issue_q;
    rd_vld_d      = 1'b0;
    rd_idx_d      = rd_idx_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    any_d         = any_q;
    dup_d         = dup_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    rsp_vld_d     = rsp_vld_q & ~rsp_o.ready;
    rsp_status_d  = rsp_status_q;
    rsp_present_d = rsp_present_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q;

    case (state_q)
      S_INIT, S_CLEAR: begin
        // invalidate one row per cycle
        mem_we_o = 1'b1;
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d        = cmd_e'(req_i.cmd);
          key_d.first  = req_i.first_key;
          key_d.second = req_i.second_key;
          key_d.third  = req_i.third_key;
          any_d        = {req_i.first_any, req_i.second_any, req_i.third_any};
          dup_d        = 1'b0;
          free_d       = 1'b0;
          cnt_d        = '0;
          if (cmd_e'(req_i.cmd) == CMD_CLEAR) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_SCAN;
            issue_d = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (issue_q) begin
          mem_re_o = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q;
          if (cnt_q == LAST) begin
            issue_d = 1'b0;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (rd_vld_q) begin
          dup_d      = dup_now;
          free_d     = free_now;
          free_idx_d = free_idx_now;
          if (cmd_q == CMD_DEL && cmp_hit_i) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = rd_idx_q;
          end
          if (rd_idx_q == LAST) begin
            state_d = S_FINISH;
            if (cmd_q == CMD_ADD && !dup_now && free_now) begin
              mem_we_o          = 1'b1;
              mem_waddr_o       = free_idx_now;
              mem_wdata_o.valid = 1'b1;
              mem_wdata_o.keys  = key_q;
            end
          end
        end
      end
      S_FINISH: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d     = 1'b1;
          rsp_present_d = (cmd_q == CMD_QUERY) & dup_q;
          if (cmd_q == CMD_ADD && dup_q) begin
            rsp_status_d = ST_DUP;
          end else if (cmd_q == CMD_ADD && !free_q) begin
            rsp_status_d = ST_FULL;
          end else begin
            rsp_status_d = ST_OK;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      cnt_q         <= '0;
      issue_q       <= 1'b0;
      rd_vld_q      <= 1'b0;
      rd_idx_q      <= '0;
      cmd_q         <= CMD_ADD;
      key_q         <= '0;
      any_q         <= '0;
      dup_q         <= 1'b0;
      free_q        <= 1'b0;
      free_idx_q    <= '0;
      rsp_vld_q     <= 1'b0;
      rsp_status_q  <= ST_OK;
      rsp_present_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      issue_q       <= issue_d;
      rd_vld_q      <= rd_vld_d;
      rd_idx_q      <= rd_idx_d;
      cmd_q         <= cmd_d;
      key_q         <= key_d;
      any_q         <= any_d;
      dup_q         <= dup_d;
      free_q        <= free_d;
      free_idx_q    <= free_idx_d;
      rsp_vld_q     <= rsp_vld_d;
      rsp_status_q  <= rsp_status_d;
      rsp_present_q <= rsp_present_d;
    end
  end

endmodule

`default_nettype wire

### rtl/wildcard_key_object_table_top.sv
// ----------------------------------------------------------------------------
// wildcard_key_object_table_top
// table of key triples with add, wildcard delete, query and clear commands
// ----------------------------------------------------------------------------
// operation: add, delete and query read every row through the single read port into
//   the comparator, one row of the table a cycle; clear writes every row invalid
// items: no new item is accepted until the last one is finished and its result is registered
// reset: a clearing pass invalidates every row, no item is accepted until it is done
`default_nettype none

module wildcard_key_object_table_top
  import wkot_pkg::*;
#(
  parameter int unsigned ENTRIES = DEF_ENTRIES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wkot_req_if.sink   req_i,
  wkot_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  row_t          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  row_t          mem_rdata;
  key_t          cmp_key;
  logic [2:0]    cmp_any;
  logic          cmp_wild;
  logic          cmp_hit;

  wkot_seq #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .cmp_key_o   (cmp_key),
    .cmp_any_o   (cmp_any),
    .cmp_wild_o  (cmp_wild),
    .cmp_hit_i   (cmp_hit)
  );

  wkot_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wkot_match u_match (
    .row_i     (mem_rdata),
    .key_i     (cmp_key),
    .any_i     (cmp_any),
    .wild_en_i (cmp_wild),
    .hit_o     (cmp_hit)
  );

endmodule

`default_nettype wire

### rtl/wkot_chk.sv
// ----------------------------------------------------------------------------
// wkot_chk
// port-level checks of the object table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wkot_chk
  import wkot_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       req_valid_i,
  input wire logic       req_ready_i,
  input wire logic       rsp_valid_i,
  input wire logic       rsp_ready_i,
  input wire logic [1:0] rsp_status_i,
  input wire logic       rsp_present_i
);

  // a pending result holds until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == ST_OK) || (rsp_status_i == ST_DUP) ||
                    (rsp_status_i == ST_FULL))
    else $error("undefined status code");

  // present only comes from a query, which always reports ok
  a_present_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_present_i |-> rsp_status_i == ST_OK)
    else $error("present set with failing status");

  // busy right after an item is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready while a command is in progress");

  a_no_instant_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !$rose(rsp_valid_i))
    else $error("result appeared one cycle after accept");

endmodule

bind wildcard_key_object_table_top wkot_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_present_i (rsp_o.present)
);

`default_nettype wire

### test/tb_wildcard_key_object_table_top.sv
// ----------------------------------------------------------------------------
// tb_wildcard_key_object_table_top
// drives add, wildcard delete, query and clear commands into the object table
// and checks every status and present flag against a behavioral copy of the
// stored triples, under random idling and back pressure on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wildcard_key_object_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wkot_pkg::*;

  localparam int unsigned ENTRIES        = DEF_ENTRIES;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct {
    cmd_e        cmd;
    key_t        key;
    logic [2:0]  any;    // first, second, third
    int unsigned phase;
    bit          drain;  // wait for every outstanding result first
    bit          hold;   // start a long receiver hold-off
  } cmd_item_t;

  typedef struct {
    status_e status;
    logic    present;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  wkot_req_if req_if ();
  wkot_rsp_if rsp_if ();

  wildcard_key_object_table_top #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // idle percentages per phase: sender first, then receiver
  int unsigned send_idle_pct [3] = '{11, 54, 0};
  int unsigned recv_idle_pct [3] = '{54, 11, 0};

  cmd_item_t   cmd_q [$];
  outcome_t    outcome_q [$];
  int unsigned build_phase = 0;
  int unsigned cur_phase = 0;
  logic [15:0] key_pool [5];

  // behavioral copy of the stored triples
  key_t        slot_key [ENTRIES];
  bit          slot_used [ENTRIES];

  bit          req_fire = 1'b0;
  bit          hold_tog = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned n_checked = 0;
  int unsigned n_add = 0, n_dup = 0, n_full = 0, n_del = 0, n_removed = 0;
  int unsigned n_query = 0, n_hit = 0, n_clear = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic outcome_t apply_command(cmd_e c, key_t k, logic fa, logic sa, logic ta);
    outcome_t o;
    bit       hit;
    int       free_slot;
    o.status  = ST_OK;
    o.present = 1'b0;
    hit       = 1'b0;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == k) hit = 1'b1;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    case (c)
      CMD_ADD: begin
        n_add++;
        if (hit) begin
          o.status = ST_DUP;
          n_dup++;
        end else if (free_slot < 0) begin
          o.status = ST_FULL;
          n_full++;
        end else begin
          slot_key[free_slot]  = k;
          slot_used[free_slot] = 1'b1;
        end
      end
      CMD_DEL: begin
        n_del++;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && (fa || slot_key[i].first == k.first) &&
              (sa || slot_key[i].second == k.second) &&
              (ta || slot_key[i].third == k.third)) begin
            slot_used[i] = 1'b0;
            n_removed++;
          end
        end
      end
      CMD_QUERY: begin
        n_query++;
        o.present = hit;
        if (hit) n_hit++;
      end
      default: begin
        n_clear++;
        for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      end
    endcase
    return o;
  endfunction

  task automatic queue_cmd(cmd_e c, logic [15:0] a, logic [15:0] b, logic [15:0] d,
                           logic [2:0] any, bit drain, bit hold);
    cmd_item_t it;
    it.cmd   = c;
    it.key   = {a, b, d};
    it.any   = any;
    it.phase = build_phase;
    it.drain = drain;
    it.hold  = hold;
    cmd_q = {cmd_q, it};
  endtask

  // mostly keys from a small pool so that duplicates, hits and deletes happen
  function automatic logic [15:0] pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(4)];
    return 16'($urandom_range(65535));
  endfunction

  task automatic queue_random_cmd(bit add_heavy);
    int unsigned r;
    cmd_e        c;
    logic [2:0]  any;
    r = $urandom_range(99);
    if (r < (add_heavy ? 65 : 35)) c = CMD_ADD;
    else if (r < (add_heavy ? 77 : 60)) c = CMD_DEL;
    else if (r < 97) c = CMD_QUERY;
    else c = CMD_CLEAR;
    if (c == CMD_DEL)
      any = {($urandom_range(99) < 35), ($urandom_range(99) < 35), ($urandom_range(99) < 35)};
    else
      any = 3'($urandom_range(7));
    queue_cmd(c, pick_key(), pick_key(), pick_key(), any, 1'b0, 1'b0);
  endtask

  // empty the table, overfill it, then poke at it while full
  task automatic queue_fill_run();
    logic [15:0] a, b, d;
    logic [15:0] a0, b0, d0;
    a0 = 16'h0;
    b0 = 16'h0;
    d0 = 16'h0;
    queue_cmd(CMD_CLEAR, pick_key(), pick_key(), pick_key(), 3'($urandom_range(7)), 1'b0, 1'b0);
    for (int i = 0; i < ENTRIES + 2; i++) begin
      a = 16'($urandom_range(65535));
      b = 16'($urandom_range(65535));
      d = 16'($urandom_range(65535));
      if (i == 0) begin
        a0 = a;
        b0 = b;
        d0 = d;
      end
      queue_cmd(CMD_ADD, a, b, d, 3'($urandom_range(7)), 1'b0, 1'b0);
    end
    // duplicate wins over full
    queue_cmd(CMD_ADD, a0, b0, d0, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, a0, b0, d0, 3'($urandom_range(7)), 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, a, b, d, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_DEL, a0, 16'h0, 16'h0, 3'b011, 1'b0, 1'b0);
    queue_cmd(CMD_ADD, a, b, d, 3'b000, 1'b0, 1'b0);
  endtask

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // driver: request channel changes on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_fire) begin
        if (cmd_q.size() != 0 && !(cmd_q[0].drain && outcome_q.size() != 0) &&
            $urandom_range(99) >= send_idle_pct[cmd_q[0].phase]) begin
          cmd_item_t it;
          it = cmd_q.pop_front();
          req_if.valid      <= 1'b1;
          req_if.cmd        <= it.cmd;
          req_if.first_key  <= it.key.first;
          req_if.second_key <= it.key.second;
          req_if.third_key  <= it.key.third;
          req_if.first_any  <= it.any[2];
          req_if.second_any <= it.any[1];
          req_if.third_any  <= it.any[0];
          cur_phase         <= it.phase;
          if (it.hold) hold_tog <= ~hold_tog;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random ready, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_tog != hold_seen) begin
        hold_seen    <= hold_tog;
        hold_left    <= HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
      end
    end
  end

  // monitor: checks results and predicts accepted commands on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      outcome_t exp_o;
      outcome_t got;
      req_fire <= req_if.valid && req_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        n_checked++;
        if (outcome_q.size() == 0) begin
          log_failure($sformatf("result with nothing outstanding: status %0d present %0b",
                                rsp_if.status, rsp_if.present));
        end else begin
          exp_o = outcome_q.pop_front();
          if (rsp_if.status !== exp_o.status)
            log_failure($sformatf("status expected %0d got %0d",
                                  exp_o.status, rsp_if.status));
          if (rsp_if.present !== exp_o.present)
            log_failure($sformatf("present expected %0b got %0b",
                                  exp_o.present, rsp_if.present));
        end
      end
      if (req_if.valid && req_if.ready) begin
        got = apply_command(cmd_e'(req_if.cmd),
                            {req_if.first_key, req_if.second_key, req_if.third_key},
                            req_if.first_any, req_if.second_any, req_if.third_any);
        outcome_q = {outcome_q, got};
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    req_if.valid      = 1'b0;
    req_if.cmd        = CMD_ADD;
    req_if.first_key  = 16'h0;
    req_if.second_key = 16'h0;
    req_if.third_key  = 16'h0;
    req_if.first_any  = 1'b0;
    req_if.second_any = 1'b0;
    req_if.third_any  = 1'b0;
    rsp_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;

    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 5; i++) key_pool[i] = 16'($urandom_range(65535));

    // directed: empty table, wildcards ignored by add and query, duplicates,
    // partial and full wildcard deletes, clear
    queue_cmd(CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 3'b111, 1'b0, 1'b0);
    queue_cmd(CMD_ADD,   16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_ADD,   16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 1'b0, 1'b0);
    queue_cmd(CMD_ADD,   16'h0000, 16'h0000, 16'h0000, 3'b101, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, 16'h0000, 16'h0000, 16'h0001, 3'b111, 1'b0, 1'b0);
    queue_cmd(CMD_ADD,   16'h0001, 16'h0002, 16'h0003, 3'b010, 1'b0, 1'b0);
    queue_cmd(CMD_ADD,   16'h0001, 16'h0005, 16'h0003, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_ADD,   16'h0007, 16'h0002, 16'h0003, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_DEL,   16'h0001, 16'h0000, 16'h0003, 3'b010, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, 16'h0001, 16'h0005, 16'h0003, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, 16'h0007, 16'h0002, 16'h0003, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_DEL,   16'h0000, 16'h0002, 16'h0000, 3'b101, 1'b0, 1'b0);
    queue_cmd(CMD_DEL,   16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_DEL,   16'h0009, 16'h0009, 16'h0009, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_ADD,   16'h0001, 16'h0002, 16'h0003, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_DEL,   16'h1234, 16'h5678, 16'h9ABC, 3'b111, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, 16'h0001, 16'h0002, 16'h0003, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_ADD,   16'hAAAA, 16'h5555, 16'hAAAA, 3'b000, 1'b0, 1'b0);
    queue_cmd(CMD_CLEAR, 16'h5555, 16'hAAAA, 16'h5555, 3'b111, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, 16'hAAAA, 16'h5555, 16'hAAAA, 3'b000, 1'b0, 1'b0);

    // phase 0: sender pauses until the directed results are all back
    queue_cmd(CMD_ADD, pick_key(), pick_key(), pick_key(), 3'b000, 1'b1, 1'b0);
    queue_fill_run();
    for (int n = 0; n < 170; n++) queue_random_cmd((n / 40) % 2 == 0);

    // phase 1: starts with the long receiver hold-off
    build_phase = 1;
    queue_cmd(CMD_ADD, pick_key(), pick_key(), pick_key(), 3'b000, 1'b0, 1'b1);
    for (int n = 0; n < 240; n++) queue_random_cmd((n / 40) % 2 == 0);

    // phase 2: no idling
    build_phase = 2;
    for (int n = 0; n < 90; n++) queue_random_cmd((n / 30) % 2 == 0);
    queue_fill_run();
    for (int n = 0; n < 90; n++) queue_random_cmd((n / 30) % 2 == 1);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 16) @(posedge clk_i);

    $display("covered %0d adds (%0d duplicate, %0d on a full table), %0d deletes removing %0d",
             n_add, n_dup, n_full, n_del, n_removed);
    $display("entries, %0d queries (%0d hits), %0d clears; %0d results checked",
             n_query, n_hit, n_clear, n_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

### wildcard_key_object_table_top.f
rtl/wkot_pkg.sv
rtl/wkot_if.sv
rtl/wkot_mem.sv
rtl/wkot_match.sv
rtl/wkot_seq.sv
rtl/wildcard_key_object_table_top.sv
rtl/wkot_chk.sv
test/tb_wildcard_key_object_table_top.sv
